// ----- sv/ffha_pkg.sv -----
// Shared types, constants and controller commands for the first-fit heap allocator.
// No dependencies; every other file imports this package.
package ffha_pkg;

  localparam int HeapGranules = 4096;
  localparam int IdxW         = $clog2(HeapGranules);
  localparam int GranW        = IdxW + 1;
  localparam int HdrBytes     = 8;

  typedef logic [GranW-1:0] gran_t;

  typedef struct packed {
    gran_t next;
    gran_t size;
    logic  used;
  } hdr_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic        done_ok;
    logic [15:0] free_byte_count;
  } rsp_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [4:0] {
    CMD_IDLE, CMD_DECODE, CMD_SETUP0, CMD_SETUP1, CMD_SETUP2,
    CMD_ACHK, CMD_AWALK, CMD_AUNLINK, CMD_ASPLIT, CMD_AFINAL,
    CMD_FCHK, CMD_FREAD, CMD_PBSTART, CMD_PBTEST, CMD_PBREAD,
    CMD_PBMERGE, CMD_PBREADC, CMD_PBWRN, CMD_PBWRIT, CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic need_setup;
    logic is_free;
    logic achk_fail;
    logic walk_more;
    logic walk_fail;
    logic do_split;
    logic fchk_fail;
    logic fread_fail;
    logic pb_walk_done;
    logic pb_need_readc;
    logic pb_it_diff;
    logic out_free;
  } status_t;

endpackage

// ----- sv/ffha_ctrl.sv -----
// Controller state machine of the heap allocator: sequences setup, list walks and writes.
// Depends on ffha_pkg for the command and status types.
module ffha_ctrl import ffha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001, S_DECODE  = 20'h00002, S_SETUP0  = 20'h00004,
    S_SETUP1  = 20'h00008, S_SETUP2  = 20'h00010, S_ACHK    = 20'h00020,
    S_AWALK   = 20'h00040, S_AUNLINK = 20'h00080, S_ASPLIT  = 20'h00100,
    S_AFINAL  = 20'h00200, S_FCHK    = 20'h00400, S_FREAD   = 20'h00800,
    S_PBSTART = 20'h01000, S_PBTEST  = 20'h02000, S_PBREAD  = 20'h04000,
    S_PBMERGE = 20'h08000, S_PBREADC = 20'h10000, S_PBWRN   = 20'h20000,
    S_PBWRIT  = 20'h40000, S_FINISH  = 20'h80000
  } state_t;

  state_t state, state_next, pb_ret;

  assign req_stall = (state != S_IDLE);
  assign pb_ret    = status.is_free ? S_FINISH : S_AFINAL;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (status.is_free) state_next = S_FCHK;
        else if (status.need_setup) state_next = S_SETUP0;
        else state_next = S_ACHK;
      end
      S_SETUP0:  state_next = S_SETUP1;
      S_SETUP1:  state_next = S_SETUP2;
      S_SETUP2:  state_next = S_ACHK;
      S_ACHK:    state_next = status.achk_fail ? S_FINISH : S_AWALK;
      S_AWALK: begin
        if (status.walk_more) state_next = S_AWALK;
        else if (status.walk_fail) state_next = S_FINISH;
        else state_next = S_AUNLINK;
      end
      S_AUNLINK: state_next = status.do_split ? S_ASPLIT : S_AFINAL;
      S_ASPLIT:  state_next = S_PBSTART;
      S_AFINAL:  state_next = S_FINISH;
      S_FCHK:    state_next = status.fchk_fail ? S_FINISH : S_FREAD;
      S_FREAD:   state_next = status.fread_fail ? S_FINISH : S_PBSTART;
      S_PBSTART: state_next = S_PBTEST;
      S_PBTEST:  state_next = status.pb_walk_done ? S_PBMERGE : S_PBREAD;
      S_PBREAD:  state_next = S_PBTEST;
      S_PBMERGE: state_next = status.pb_need_readc ? S_PBREADC : S_PBWRN;
      S_PBREADC: state_next = S_PBWRN;
      S_PBWRN:   state_next = status.pb_it_diff ? S_PBWRIT : pb_ret;
      S_PBWRIT:  state_next = pb_ret;
      S_FINISH:  if (status.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Map state to datapath command
  always_comb begin
    case (state)
      S_IDLE:    cmd = CMD_IDLE;
      S_DECODE:  cmd = CMD_DECODE;
      S_SETUP0:  cmd = CMD_SETUP0;
      S_SETUP1:  cmd = CMD_SETUP1;
      S_SETUP2:  cmd = CMD_SETUP2;
      S_ACHK:    cmd = CMD_ACHK;
      S_AWALK:   cmd = CMD_AWALK;
      S_AUNLINK: cmd = CMD_AUNLINK;
      S_ASPLIT:  cmd = CMD_ASPLIT;
      S_AFINAL:  cmd = CMD_AFINAL;
      S_FCHK:    cmd = CMD_FCHK;
      S_FREAD:   cmd = CMD_FREAD;
      S_PBSTART: cmd = CMD_PBSTART;
      S_PBTEST:  cmd = CMD_PBTEST;
      S_PBREAD:  cmd = CMD_PBREAD;
      S_PBMERGE: cmd = CMD_PBMERGE;
      S_PBREADC: cmd = CMD_PBREADC;
      S_PBWRN:   cmd = CMD_PBWRN;
      S_PBWRIT:  cmd = CMD_PBWRIT;
      S_FINISH:  cmd = CMD_FINISH;
      default:   cmd = CMD_IDLE;
    endcase
  end

endmodule

// ----- sv/ffha_dp.sv -----
// Datapath of the heap allocator: header memory, list registers, checks and result register.
// Depends on ffha_pkg; driven by commands from ffha_ctrl.
module ffha_dp import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  hdr_t mem [HeapGranules];

  logic [31:0] cfg_base;
  logic [15:0] cfg_bytes;
  logic        ready;
  logic [31:0] start;
  gran_t       end_g, head;
  logic [15:0] remaining;
  req_t        item;
  gran_t       needg, blk, blk_size, prev;
  logic        prev_root;
  hdr_t        prev_hdr, blk_hdr;
  gran_t       pb_n, pb_sn, it, c;
  logic        it_root;
  hdr_t        it_hdr, c_hdr;
  logic        merge_c;
  logic [31:0] res_addr;
  logic        res_ok;
  hdr_t        rd_data;
  logic        rd_oob;

  gran_t       rd_gran, wr_gran;
  logic        wr_req;
  hdr_t        wr_data;
  hdr_t        hdr_eff;

  // Setup arithmetic
  logic [32:0] start33;
  logic [3:0]  gap;
  logic [15:0] len;
  logic [12:0] t_raw;
  gran_t       t_cap, end_new;
  // Allocate arithmetic
  logic [32:0] need;
  gran_t       rem_g, nb;
  // Free arithmetic
  logic [31:0] off, off2;
  logic [28:0] g_full;
  // Insertion arithmetic
  logic        merge_prev;
  gran_t       n_new, sn_new;
  logic [GranW:0] it_end, n_end;

  assign hdr_eff = rd_oob ? '0 : rd_data;

  assign start33 = ({1'b0, cfg_base} + 33'd7) & ~33'd7;
  assign gap     = 4'(start33 - {1'b0, cfg_base});
  assign len     = (cfg_bytes >= 16'(gap)) ? cfg_bytes - 16'(gap) : 16'd0;
  assign t_raw   = len[15:3];
  assign t_cap   = (t_raw > 13'(HeapGranules)) ? GranW'(HeapGranules) : GranW'(t_raw);
  assign end_new = (t_cap < GranW'(2)) ? '0 : t_cap - GranW'(1);

  assign need  = ({1'b0, item.request_bytes} + 33'(HdrBytes) + 33'd7) & ~33'd7;
  assign rem_g = blk_hdr.size - needg;
  assign nb    = blk + needg;

  assign off    = item.release_address - start;
  assign off2   = off - 32'(HdrBytes);
  assign g_full = off2[31:3];

  assign it_end     = {1'b0, it} + {1'b0, it_hdr.size};
  assign merge_prev = !it_root && (it_end == {1'b0, pb_n});
  assign n_new      = merge_prev ? it : pb_n;
  assign sn_new     = merge_prev ? it_hdr.size + pb_sn : pb_sn;
  assign n_end      = {1'b0, n_new} + {1'b0, sn_new};

  // Decision flags for the controller
  always_comb begin
    status.need_setup    = !ready;
    status.is_free       = (item.opcode == OP_FREE);
    status.achk_fail     = (item.request_bytes == 32'd0) || item.request_bytes[31] ||
                           (need > {17'd0, remaining});
    status.walk_more     = (hdr_eff.size < needg) && (hdr_eff.next != '0);
    status.walk_fail     = (blk == end_g) || rd_oob || (hdr_eff.size < needg);
    status.do_split      = (rem_g > GranW'(2));
    status.fchk_fail     = (item.release_address == 32'd0) || !ready ||
                           (off < 32'(HdrBytes)) || (off2[2:0] != 3'd0) ||
                           (g_full >= 29'(end_g));
    status.fread_fail    = !hdr_eff.used || (hdr_eff.next != '0);
    status.pb_walk_done  = (c >= pb_n) || (!it_root && (c == '0));
    status.pb_need_readc = (n_end == {1'b0, c}) && (c != end_g);
    status.pb_it_diff    = it_root || (it != pb_n);
    status.out_free      = !rsp_valid || !rsp_stall;
  end

  // Read address per command
  always_comb begin
    case (cmd)
      CMD_ACHK:  rd_gran = head;
      CMD_AWALK: rd_gran = hdr_eff.next;
      CMD_FCHK:  rd_gran = GranW'(g_full);
      default:   rd_gran = c;
    endcase
  end

  // Write port per command
  always_comb begin
    wr_req  = 1'b0;
    wr_gran = '0;
    wr_data = '0;
    case (cmd)
      CMD_SETUP1: begin
        wr_req  = (end_g != '0);
        wr_gran = end_g;
      end
      CMD_SETUP2: begin
        wr_req  = (end_g != '0);
        wr_data = '{next: end_g, size: end_g, used: 1'b0};
      end
      CMD_AUNLINK: begin
        wr_req  = !prev_root;
        wr_gran = prev;
        wr_data = '{next: blk_hdr.next, size: prev_hdr.size, used: prev_hdr.used};
      end
      CMD_ASPLIT: begin
        wr_req  = 1'b1;
        wr_gran = nb;
        wr_data = '{next: '0, size: rem_g, used: 1'b0};
      end
      CMD_AFINAL: begin
        wr_req  = 1'b1;
        wr_gran = blk;
        wr_data = '{next: '0, size: blk_size, used: 1'b1};
      end
      CMD_FREAD: begin
        wr_req  = !status.fread_fail;
        wr_gran = blk;
        wr_data = '{next: hdr_eff.next, size: hdr_eff.size, used: 1'b0};
      end
      CMD_PBWRN: begin
        wr_req  = 1'b1;
        wr_gran = pb_n;
        wr_data = merge_c ? '{next: c_hdr.next, size: pb_sn + c_hdr.size, used: 1'b0}
                          : '{next: c, size: pb_sn, used: 1'b0};
      end
      CMD_PBWRIT: begin
        wr_req  = !it_root;
        wr_gran = it;
        wr_data = '{next: pb_n, size: it_hdr.size, used: it_hdr.used};
      end
      default: wr_req = 1'b0;
    endcase
  end

  // Header memory
  always_ff @(posedge clk) begin
    if (wr_req && !wr_gran[GranW-1]) mem[wr_gran[IdxW-1:0]] <= wr_data;
    rd_data <= mem[rd_gran[IdxW-1:0]];
    rd_oob  <= rd_gran[GranW-1];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base  <= 32'd0;
      cfg_bytes <= 16'd32768;
      ready     <= 1'b0;
      start     <= 32'd0;
      end_g     <= '0;
      head      <= '0;
      remaining <= 16'd0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_HEAP_BASE:  cfg_base <= cfg_data;
          CFG_HEAP_BYTES: cfg_bytes <= cfg_data[15:0];
          default:        cfg_base <= cfg_base;
        endcase
      end
      // Raise the result on finish, drop it once taken
      if (cmd == CMD_FINISH && status.out_free) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (cmd)
        CMD_SETUP0: begin
          ready     <= 1'b1;
          start     <= start33[31:0];
          end_g     <= end_new;
          head      <= '0;
          remaining <= {end_new[12:0], 3'd0};
        end
        CMD_AUNLINK: if (prev_root) head <= blk_hdr.next;
        CMD_AFINAL:  remaining <= remaining - {blk_size[12:0], 3'd0};
        CMD_FREAD: begin
          if (!status.fread_fail) remaining <= remaining + {hdr_eff.size[12:0], 3'd0};
        end
        CMD_PBWRIT:  if (it_root) head <= pb_n;
        default:     head <= head;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_IDLE: if (req_valid) item <= req;
      CMD_DECODE: begin
        res_addr <= 32'd0;
        res_ok   <= 1'b0;
      end
      CMD_ACHK: begin
        needg     <= need[GranW+2:3];
        blk       <= head;
        prev_root <= 1'b1;
      end
      CMD_AWALK: begin
        blk_hdr <= hdr_eff;
        if (status.walk_more) begin
          prev      <= blk;
          prev_hdr  <= hdr_eff;
          prev_root <= 1'b0;
          blk       <= hdr_eff.next;
        end
      end
      CMD_AUNLINK: blk_size <= blk_hdr.size;
      CMD_ASPLIT: begin
        blk_size <= needg;
        pb_n     <= nb;
        pb_sn    <= rem_g;
      end
      CMD_AFINAL: begin
        res_ok   <= 1'b1;
        res_addr <= start + {16'd0, blk[12:0], 3'd0} + 32'(HdrBytes);
      end
      CMD_FCHK: blk <= GranW'(g_full);
      CMD_FREAD: begin
        res_ok <= !status.fread_fail;
        pb_n   <= blk;
        pb_sn  <= hdr_eff.size;
      end
      CMD_PBSTART: begin
        it_root <= 1'b1;
        c       <= head;
      end
      CMD_PBTEST: if (!status.pb_walk_done) begin
        it      <= c;
        it_root <= 1'b0;
      end
      CMD_PBREAD: begin
        it_hdr <= hdr_eff;
        c      <= hdr_eff.next;
      end
      CMD_PBMERGE: begin
        pb_n    <= n_new;
        pb_sn   <= sn_new;
        merge_c <= status.pb_need_readc;
      end
      CMD_PBREADC: c_hdr <= hdr_eff;
      CMD_FINISH: if (status.out_free) begin
        rsp.result_address  <= res_addr;
        rsp.done_ok         <= res_ok;
        rsp.free_byte_count <= remaining;
      end
      default: item <= item;
    endcase
  end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// First-fit heap allocator over 8-byte granules with an address-ordered, coalescing free list.
// Instantiates ffha_ctrl and ffha_dp; types from ffha_pkg.
//
// Each item returns exactly one result item. The heap is built on the first allocate,
// in states SETUP0 to SETUP2. An allocate walks the free list one header read per cycle;
// when the block is split, the remainder is reinserted into the free list. A free
// reinserts its block in address order, walking the free blocks below it, merging with
// the following block and linking behind a preceding one. A result held by rsp_stall
// keeps the controller in its finish state and the request side stalled.
// The header memory has one read and one write port. Configuration takes effect only
// before the first allocate; later writes are kept but not used.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  cmd_t    cmd;
  status_t status;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ffha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for first_fit_heap_allocator: random and directed allocate/free items.
// Depends on ffha_pkg and the RTL; responses are checked against an in-bench heap predictor.
`timescale 1ns / 100ps

module testbench;
  import ffha_pkg::*;

  localparam int unsigned NoParent = 32'hFFFF_FFFF;
  localparam int unsigned HdrB     = 8;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Heap mirror
  int unsigned blk_next [HeapGranules];
  int unsigned blk_size [HeapGranules];
  bit          blk_used [HeapGranules];
  bit          blk_seen [HeapGranules];
  int unsigned free_head, end_gran, bytes_left, heap_origin;
  bit          heap_built;
  logic [31:0] base_reg;
  logic [15:0] length_reg;

  rsp_t        pending_rsp[$];
  logic [31:0] live_addrs[$];
  logic [31:0] handed_out[$];
  int          mismatches;
  bit          quiet;

  function automatic int unsigned link_at(int unsigned g);
    if (g == NoParent) return free_head;
    if (g < HeapGranules) return blk_next[g];
    return 0;
  endfunction

  function automatic void set_link_at(int unsigned g, int unsigned v);
    if (g == NoParent) free_head = v;
    else if (g < HeapGranules) begin
      blk_next[g] = v;
      blk_seen[g] = 1'b1;
    end
  endfunction

  function automatic int unsigned size_at(int unsigned g);
    return (g < HeapGranules) ? blk_size[g] : 0;
  endfunction

  function automatic void set_size_at(int unsigned g, int unsigned v);
    if (g < HeapGranules) begin
      blk_size[g] = v;
      blk_seen[g] = 1'b1;
    end
  endfunction

  // Insert block n into the address-ordered list, merging with neighbors
  function automatic void reinsert(int unsigned n);
    int unsigned it, c, steps;
    it = NoParent;
    steps = 0;
    while (steps <= HeapGranules) begin
      c = link_at(it);
      if (c >= n) break;
      if (it != NoParent && c == 0) break;
      it = c;
      steps++;
    end
    if (it != NoParent && it + size_at(it) == n) begin
      set_size_at(it, size_at(it) + size_at(n));
      n = it;
    end
    c = link_at(it);
    if (n + size_at(n) == c) begin
      if (c != end_gran) begin
        set_size_at(n, size_at(n) + size_at(c));
        set_link_at(n, link_at(c));
      end else begin
        set_link_at(n, end_gran);
      end
    end else begin
      set_link_at(n, c);
    end
    if (it != n) set_link_at(it, n);
  endfunction

  function automatic void build_heap();
    longint unsigned start, gap, len, t;
    start = (longint'(base_reg) + 7) & ~64'd7;
    gap = start - base_reg;
    len = (length_reg >= gap) ? length_reg - gap : 0;
    t = len >> 3;
    if (t > HeapGranules) t = HeapGranules;
    heap_origin = start[31:0];
    heap_built = 1'b1;
    free_head = 0;
    end_gran = 0;
    bytes_left = 0;
    if (t < 2) return;
    end_gran = 32'(t) - 1;
    set_size_at(end_gran, 0);
    set_link_at(end_gran, 0);
    blk_used[end_gran] = 1'b0;
    set_size_at(0, end_gran);
    set_link_at(0, end_gran);
    blk_used[0] = 1'b0;
    bytes_left = end_gran * 8;
  endfunction

  function automatic bit alloc_block(logic [31:0] want, output logic [31:0] addr);
    longint unsigned need;
    int unsigned needg, prev, blk, steps, nb;
    addr = '0;
    if (!heap_built) build_heap();
    if (want == 0 || want[31]) return 1'b0;
    need = (longint'(want) + HdrB + 7) & ~64'd7;
    if (need > bytes_left) return 1'b0;
    needg = 32'(need >> 3);
    prev = NoParent;
    blk = free_head;
    steps = 0;
    while (steps <= HeapGranules && size_at(blk) < needg && link_at(blk) != 0) begin
      prev = blk;
      blk = link_at(blk);
      steps++;
    end
    if (blk == end_gran || blk >= HeapGranules || size_at(blk) < needg) return 1'b0;
    set_link_at(prev, link_at(blk));
    // Split when the leftover is larger than two headers
    if ((size_at(blk) - needg) * 8 > 2 * HdrB) begin
      nb = blk + needg;
      set_size_at(nb, size_at(blk) - needg);
      if (nb < HeapGranules) blk_used[nb] = 1'b0;
      set_size_at(blk, needg);
      reinsert(nb);
    end
    bytes_left = (bytes_left - size_at(blk) * 8) & 32'hFFFF;
    blk_used[blk] = 1'b1;
    set_link_at(blk, 0);
    addr = heap_origin + blk * 8 + HdrB;
    return 1'b1;
  endfunction

  function automatic bit release_block(logic [31:0] a);
    logic [31:0] off;
    int unsigned g;
    if (a == 0 || !heap_built) return 1'b0;
    off = a - heap_origin;
    if (off < HdrB) return 1'b0;
    off -= HdrB;
    if (off[2:0] != 0) return 1'b0;
    g = off >> 3;
    if (g >= end_gran || g >= HeapGranules) return 1'b0;
    if (!blk_used[g] || blk_next[g] != 0) return 1'b0;
    blk_used[g] = 1'b0;
    bytes_left = (bytes_left + blk_size[g] * 8) & 32'hFFFF;
    reinsert(g);
    return 1'b1;
  endfunction

  function automatic rsp_t predict_heap(req_t r);
    rsp_t o;
    logic [31:0] addr;
    bit ok;
    if (r.opcode == OP_ALLOC) ok = alloc_block(r.request_bytes, addr);
    else begin
      ok = release_block(r.release_address);
      addr = '0;
    end
    o.result_address = ok ? addr : '0;
    o.done_ok = ok;
    o.free_byte_count = bytes_left[15:0];
    return o;
  endfunction

  // Replace a free address that would read a never-written header by 0
  function automatic logic [31:0] guard_addr(logic [31:0] a);
    logic [31:0] off;
    int unsigned g;
    if (!heap_built) return a;
    off = a - heap_origin;
    if (off < HdrB || off[2:0] != 0) return a;
    g = (off - HdrB) >> 3;
    if (g < end_gran && g < HeapGranules && !blk_seen[g]) return '0;
    return a;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive one item, predict on acceptance
  task automatic send_item(logic op, logic [31:0] bytes, logic [31:0] addr);
    req_t r;
    rsp_t e;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk);
    r.opcode = op;
    r.request_bytes = bytes;
    r.release_address = (op == OP_FREE) ? guard_addr(addr) : addr;
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    e = predict_heap(r);
    pending_rsp.push_back(e);
    if (op == OP_ALLOC && e.done_ok) begin
      live_addrs.push_back(e.result_address);
      handed_out.push_back(e.result_address);
    end
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic send_alloc(logic [31:0] bytes);
    send_item(OP_ALLOC, bytes, $urandom());
  endtask

  task automatic send_free(logic [31:0] a);
    send_item(OP_FREE, $urandom(), a);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    if (idx == CFG_HEAP_BASE) base_reg = v;
    else length_reg = v[15:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_rsp.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Response stall generator
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 8);
      repeat (n) begin
        @(negedge clk);
        rsp_stall = 1'b1;
      end
      @(negedge clk);
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Compare each response with the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", rsp);
        mismatches++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.result_address !== e.result_address) begin
          $error("result_address: expected %h actual %h", e.result_address, rsp.result_address);
          mismatches++;
        end
        if (rsp.done_ok !== e.done_ok) begin
          $error("done_ok: expected %b actual %b", e.done_ok, rsp.done_ok);
          mismatches++;
        end
        if (rsp.free_byte_count !== e.free_byte_count) begin
          $error("free_byte_count: expected %0d actual %0d", e.free_byte_count,
                 rsp.free_byte_count);
          mismatches++;
        end
      end
    end
  end

  // Frees before setup, then several register settings ahead of the first allocate
  task automatic test_early_config();
    send_free(32'h0);
    send_free(32'h1000_0010);
    send_free(32'hFFFF_FFFF);
    wait_idle();
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_HEAP_BYTES, 32'd0);
    write_reg(CFG_HEAP_BYTES, 32'd32768);
    write_reg(CFG_HEAP_BASE, 32'h0);
    // Unaligned base so the alignment gap shortens the region
    write_reg(CFG_HEAP_BASE, 32'h1000_0003);
    write_reg(CFG_HEAP_BYTES, 32'd4000);
  endtask

  // Null requests, fits, misfits and every kind of ignored free after setup
  task automatic test_directed();
    logic [31:0] a0, a1;
    quiet = 1'b1;
    send_alloc(32'h0);
    send_alloc(32'h8000_0000);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'h7FFF_FFFF);
    send_alloc(32'd1);
    send_alloc(32'd8);
    send_alloc(32'd9);
    send_alloc(32'd24);
    send_alloc(32'd3900);
    send_alloc(32'd100);
    wait_idle();
    a0 = live_addrs.pop_front();
    a1 = live_addrs.pop_front();
    send_free(a1);
    send_free(a1);
    send_free(a0);
    send_free(a0 + 32'd1);
    send_free(heap_origin);
    send_free(heap_origin + end_gran * 8 + HdrB);
    send_free(32'h0);
    // Refill the merged hole; its leftover is too small for a split
    send_alloc(32'd8);
    while (live_addrs.size() > 0) send_free(live_addrs.pop_front());
    send_alloc(32'd3976);
    send_alloc(32'd1);
    wait_idle();
    quiet = 1'b0;
  endtask

  // Register writes after setup must not change behavior
  task automatic test_late_config();
    wait_idle();
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_HEAP_BYTES, 32'd32768);
    send_alloc(32'd40);
    wait_idle();
    write_reg(CFG_HEAP_BASE, 32'h0);
    write_reg(CFG_HEAP_BYTES, 32'd0);
    send_alloc(32'd16);
  endtask

  // Mostly real alloc/free traffic, some null sizes, double frees and stray addresses
  task automatic test_random_traffic(int count);
    int k, pick, idx;
    logic [31:0] a;
    for (k = 0; k < count; k++) begin
      if (k % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) send_alloc($urandom_range(1, 120));
      else if (pick < 45) send_alloc($urandom_range(121, 4000));
      else if (pick < 48) send_alloc($urandom_range(0, 1) ? 32'h0 : ($urandom() | 32'h8000_0000));
      else if (pick < 50) send_alloc($urandom());
      else if (pick < 85 && live_addrs.size() > 0) begin
        idx = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        send_free(a);
      end else if (pick < 93 && handed_out.size() > 0) begin
        a = handed_out[$urandom_range(0, handed_out.size() - 1)];
        send_free(($urandom_range(0, 3) == 0) ? a + $urandom_range(1, 7) : a);
      end else begin
        send_free($urandom());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    mismatches = 0;
    quiet = 1'b0;
    heap_built = 1'b0;
    heap_origin = 0;
    free_head = 0;
    end_gran = 0;
    bytes_left = 0;
    base_reg = '0;
    length_reg = 16'd32768;
    for (int i = 0; i < HeapGranules; i++) begin
      blk_next[i] = 0;
      blk_size[i] = 0;
      blk_used[i] = 1'b0;
      blk_seen[i] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_early_config();
    test_directed();
    test_late_config();
    test_random_traffic(520);
    wait_idle();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_rsp.size() != 0) $error("%0d responses never arrived", pending_rsp.size());
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
